// File: sv/sktab_pkg.sv
// Shared types and codes for the sorted key table.
// Used by sktab_cell and sorted_key_table; depends on nothing.
package sktab_pkg;

   localparam int KEY_BITS   = 32;
   localparam int PORT_PAY_W = 32;
   localparam int CAP_BITS   = 7;

   localparam logic [CAP_BITS-1:0] CAP_RESET = 7'd64;

   // request kinds
   localparam logic [1:0] FUNC_INSERT = 2'd0;
   localparam logic [1:0] FUNC_DELETE = 2'd1;
   localparam logic [1:0] FUNC_LOOKUP = 2'd2;

   // result status codes
   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_FULL      = 3'd1;
   localparam logic [2:0] STATUS_DUPLICATE = 3'd2;
   localparam logic [2:0] STATUS_EMPTY     = 3'd3;
   localparam logic [2:0] STATUS_NOT_FOUND = 3'd4;

   typedef struct packed {
      logic [1:0]                   func;
      logic signed [KEY_BITS-1:0]   key_id;
      logic [PORT_PAY_W-1:0]        entry_payload;
   } req_type;

   typedef struct packed {
      logic [2:0]                   status;
      logic                         found;
      logic [PORT_PAY_W-1:0]        payload_out;
      logic [CAP_BITS-1:0]          entry_count;
   } rsp_type;

   // shift command broadcast to every cell
   typedef struct packed {
      logic ins;
      logic del;
   } cell_cmd_type;

endpackage

// File: sv/sktab_cell.sv
// One slot of the sorted key table: holds a key and payload, compares the key
// against the incoming request key and shifts with its neighbors. Uses sktab_pkg.
module sktab_cell #(
   parameter int PAYLOAD_BITS = 32,
   parameter int CNT_W        = 7,
   parameter int INDEX        = 0
) (
   input  logic                                  clock,
   input  logic                                  cmp_en,
   input  logic signed [sktab_pkg::KEY_BITS-1:0] cmp_key,
   input  logic [CNT_W-1:0]                      count,
   input  sktab_pkg::cell_cmd_type               cmd,
   input  logic signed [sktab_pkg::KEY_BITS-1:0] new_key,
   input  logic [PAYLOAD_BITS-1:0]               new_pay,
   input  logic                                  left_lt,
   input  logic signed [sktab_pkg::KEY_BITS-1:0] left_key,
   input  logic [PAYLOAD_BITS-1:0]               left_pay,
   input  logic signed [sktab_pkg::KEY_BITS-1:0] right_key,
   input  logic [PAYLOAD_BITS-1:0]               right_pay,
   output logic signed [sktab_pkg::KEY_BITS-1:0] key,
   output logic [PAYLOAD_BITS-1:0]               pay,
   output logic                                  lt,
   output logic                                  eq
);

   logic signed [sktab_pkg::KEY_BITS-1:0] key_ff, key_in;
   logic [PAYLOAD_BITS-1:0]               pay_ff, pay_in;
   logic                                  lt_ff, lt_in;
   logic                                  eq_ff, eq_in;
   logic                                  occupied;

   assign occupied = CNT_W'(INDEX) < count;

   always_comb begin
      lt_in = lt_ff;
      eq_in = eq_ff;
      if (cmp_en) begin
         lt_in = occupied && (key_ff < cmp_key);
         eq_in = occupied && (key_ff == cmp_key);
      end
   end

   always_comb begin
      key_in = key_ff;
      pay_in = pay_ff;
      priority if (cmd.ins) begin
         if (!left_lt) begin
            // slot lies above the insert point: take the left neighbor
            key_in = left_key;
            pay_in = left_pay;
         end else if (!lt_ff) begin
            key_in = new_key;
            pay_in = new_pay;
         end
      end else if (cmd.del) begin
         if (!lt_ff) begin
            key_in = right_key;
            pay_in = right_pay;
         end
      end else begin
         // no shift: hold the slot
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      pay_ff <= pay_in;
      lt_ff  <= lt_in;
      eq_ff  <= eq_in;
   end

   assign key = key_ff;
   assign pay = pay_ff;
   assign lt  = lt_ff;
   assign eq  = eq_ff;

endmodule

// File: sv/sorted_key_table.sv
// Sorted key table top level: a row of sktab_cell slots, request and result
// registers, and the capacity register. Uses sktab_pkg and sktab_cell.
//
// Keeps up to DEPTH entries in ascending signed key order. At the accept edge
// every slot compares its key with the request key in parallel; in S_UPDATE,
// once the previous result can be replaced, the row shifts up (insert) or
// down (delete) by one slot in a single step and the result is registered.
// The block takes one request at a time; req_stall stays high in S_UPDATE,
// which holds while the previous result waits on rsp_stall. There is no
// clearing pass after reset; slots above the entry count are never read.
module sorted_key_table #(
   parameter int DEPTH        = 64,
   parameter int PAYLOAD_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  sktab_pkg::req_type                  req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output sktab_pkg::rsp_type                  rsp_data,
   input  logic                                csr_write_enable,
   input  logic [sktab_pkg::CAP_BITS-1:0]      csr_write_data
);

   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int CMP_W   = (CNT_W > sktab_pkg::CAP_BITS) ? CNT_W : sktab_pkg::CAP_BITS;
   localparam int WIDE_W  = (PAYLOAD_BITS > sktab_pkg::PORT_PAY_W) ? PAYLOAD_BITS
                                                                   : sktab_pkg::PORT_PAY_W;

   typedef enum logic [1:0] {
      S_IDLE   = 2'b01,
      S_UPDATE = 2'b10
   } state_type;

   state_type                         state_ff, state_in;
   sktab_pkg::req_type                req_ff, req_in;
   logic [CNT_W-1:0]                  count_ff, count_in;
   logic [sktab_pkg::CAP_BITS-1:0]    cap_ff, cap_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   sktab_pkg::rsp_type                rsp_ff, rsp_in;

   logic                              accept;
   logic                              can_load;
   logic                              hit;
   logic                              full;
   logic                              do_ins;
   logic                              do_del;
   sktab_pkg::cell_cmd_type           cmd;
   logic [CMP_W-1:0]                  eff_cap;
   logic [CMP_W-1:0]                  count_wide;
   logic [WIDE_W-1:0]                 new_pay_wide;
   logic [PAYLOAD_BITS-1:0]           new_pay;
   logic [PAYLOAD_BITS-1:0]           hit_pay;
   logic [WIDE_W-1:0]                 hit_pay_wide;

   logic signed [sktab_pkg::KEY_BITS-1:0] cell_key [DEPTH];
   logic [PAYLOAD_BITS-1:0]               cell_pay [DEPTH];
   logic [DEPTH-1:0]                      lt_vec;
   logic [DEPTH-1:0]                      eq_vec;

   assign accept   = req_valid && !req_stall;
   assign can_load = (state_ff == S_UPDATE) && (!rsp_valid_ff || !rsp_stall);

   assign new_pay_wide = WIDE_W'(req_ff.entry_payload);
   assign new_pay      = new_pay_wide[PAYLOAD_BITS-1:0];

   // effective capacity: register value saturated to DEPTH
   always_comb begin
      eff_cap = CMP_W'(cap_ff);
      if (eff_cap > CMP_W'(DEPTH)) begin
         eff_cap = CMP_W'(DEPTH);
      end
   end

   assign count_wide = CMP_W'(count_ff);
   assign full       = count_wide >= eff_cap;
   assign hit        = |eq_vec;

   always_comb begin
      hit_pay = '0;
      for (int i = 0; i < DEPTH; i++) begin
         hit_pay = hit_pay | (eq_vec[i] ? cell_pay[i] : '0);
      end
   end
   assign hit_pay_wide = WIDE_W'(hit_pay);

   assign do_ins = can_load && (req_ff.func == sktab_pkg::FUNC_INSERT) && !full && !hit;
   assign do_del = can_load && (req_ff.func == sktab_pkg::FUNC_DELETE) && hit;
   assign cmd.ins = do_ins;
   assign cmd.del = do_del;

   generate
      for (genvar g = 0; g < DEPTH; g++) begin : g_cell
         logic                                  left_lt;
         logic signed [sktab_pkg::KEY_BITS-1:0] left_key;
         logic [PAYLOAD_BITS-1:0]               left_pay;
         logic signed [sktab_pkg::KEY_BITS-1:0] right_key;
         logic [PAYLOAD_BITS-1:0]               right_pay;

         if (g == 0) begin : g_first
            assign left_lt  = 1'b1;
            assign left_key = cell_key[g];
            assign left_pay = cell_pay[g];
         end else begin : g_mid
            assign left_lt  = lt_vec[g-1];
            assign left_key = cell_key[g-1];
            assign left_pay = cell_pay[g-1];
         end

         if (g == DEPTH - 1) begin : g_last
            assign right_key = cell_key[g];
            assign right_pay = cell_pay[g];
         end else begin : g_inner
            assign right_key = cell_key[g+1];
            assign right_pay = cell_pay[g+1];
         end

         sktab_cell #(
            .PAYLOAD_BITS (PAYLOAD_BITS),
            .CNT_W        (CNT_W),
            .INDEX        (g)
         ) u_cell (
            .clock     (clock),
            .cmp_en    (accept),
            .cmp_key   (req_data.key_id),
            .count     (count_ff),
            .cmd       (cmd),
            .new_key   (req_ff.key_id),
            .new_pay   (new_pay),
            .left_lt   (left_lt),
            .left_key  (left_key),
            .left_pay  (left_pay),
            .right_key (right_key),
            .right_pay (right_pay),
            .key       (cell_key[g]),
            .pay       (cell_pay[g]),
            .lt        (lt_vec[g]),
            .eq        (eq_vec[g])
         );
      end
   endgenerate

   always_comb begin
      state_in = state_ff;
      req_in   = req_ff;
      if (accept) begin
         req_in   = req_data;
         state_in = S_UPDATE;
      end else if (can_load) begin
         state_in = S_IDLE;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (do_ins) begin
         count_in = count_ff + 1'b1;
      end else if (do_del) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_comb begin
      logic [CMP_W-1:0] next_count_wide;
      next_count_wide = CMP_W'(count_in);
      rsp_in = rsp_ff;
      if (can_load) begin
         rsp_in.status      = sktab_pkg::STATUS_OK;
         rsp_in.found       = 1'b0;
         rsp_in.payload_out = '0;
         rsp_in.entry_count = next_count_wide[sktab_pkg::CAP_BITS-1:0];
         unique case (req_ff.func)
            sktab_pkg::FUNC_INSERT: begin
               priority if (full) begin
                  rsp_in.status = sktab_pkg::STATUS_FULL;
               end else if (hit) begin
                  rsp_in.status = sktab_pkg::STATUS_DUPLICATE;
               end else begin
                  // room for a new key: status stays ok
               end
            end
            sktab_pkg::FUNC_DELETE: begin
               priority if (count_ff == '0) begin
                  rsp_in.status = sktab_pkg::STATUS_EMPTY;
               end else if (!hit) begin
                  rsp_in.status = sktab_pkg::STATUS_NOT_FOUND;
               end else begin
                  // key present: status stays ok
               end
            end
            sktab_pkg::FUNC_LOOKUP: begin
               if (hit) begin
                  rsp_in.found       = 1'b1;
                  rsp_in.payload_out = hit_pay_wide[sktab_pkg::PORT_PAY_W-1:0];
               end else begin
                  rsp_in.status = sktab_pkg::STATUS_NOT_FOUND;
               end
            end
            default: begin
               // unused request code: table untouched, plain result
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (can_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign cap_in = csr_write_enable ? csr_write_data : cap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         cap_ff       <= sktab_pkg::CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above table depth");

   a_lt_prefix: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UPDATE) |-> $onehot((DEPTH + 1)'(lt_vec) + 1'b1))
      else $error("less-than flags do not form a prefix; table out of order");

   a_single_match: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UPDATE) |-> $onehot0(eq_vec))
      else $error("key matched in more than one slot");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      do_ins |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("insert did not advance the entry count");

endmodule

// File: bench/sorted_key_table_tb.sv
// Self-checking bench for sorted_key_table: directed table, then random traffic.
// Depends on sktab_pkg and the sorted_key_table RTL; predicts each result locally.
module sorted_key_table_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD   = 8;
   localparam int TABLE_DEPTH  = 64;
   localparam int LONG_HOLD    = 300;
   localparam int STUCK_LIMIT  = 4000;
   localparam int PHASE_COUNT  = 8;
   localparam int PHASE_ITEMS  = 131;
   localparam int POOL_SIZE    = 96;

   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   localparam logic signed [sktab_pkg::KEY_BITS-1:0] KEY_MIN = 32'h8000_0000;
   localparam logic signed [sktab_pkg::KEY_BITS-1:0] KEY_MAX = 32'h7fff_ffff;

   typedef enum int {MIX_FILL, MIX_EVEN, MIX_DRAIN} mix_type;

   typedef struct {
      bit                             is_cfg;
      logic [sktab_pkg::CAP_BITS-1:0] cfg_value;
      sktab_pkg::req_type             req;
      bit                             typed;
      sktab_pkg::rsp_type             rsp;
   } stim_row_type;

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_stall;
   sktab_pkg::req_type             req_data;
   logic                           rsp_valid;
   logic                           rsp_stall;
   sktab_pkg::rsp_type             rsp_data;
   logic                           csr_write_enable;
   logic [sktab_pkg::CAP_BITS-1:0] csr_write_data;

   // side band that travels with the offered request
   bit                 item_typed;
   sktab_pkg::rsp_type item_typed_rsp;

   // local copy of the table
   logic signed [sktab_pkg::KEY_BITS-1:0] key_copy [TABLE_DEPTH];
   logic [sktab_pkg::PORT_PAY_W-1:0]      pay_copy [TABLE_DEPTH];
   int                                    fill_copy;
   logic [sktab_pkg::CAP_BITS-1:0]        capacity_copy;

   sktab_pkg::rsp_type expected_results[$];
   stim_row_type       directed_rows[$];
   logic signed [sktab_pkg::KEY_BITS-1:0] key_pool [POOL_SIZE];

   sktab_pkg::rsp_type predicted;
   sktab_pkg::rsp_type wanted;
   int      errors;
   int      stuck_cycles;
   int      func_seen [4];
   int      status_seen [8];
   int      peak_fill;
   bit      hold_request;
   bit      quiet;

   sorted_key_table u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial clock = 1'b0;
   always #(CLK_PERIOD / 2) clock = ~clock;

   // Apply one request to the local table and return the result it should give.
   function automatic sktab_pkg::rsp_type apply_request(sktab_pkg::req_type r);
      sktab_pkg::rsp_type                    res;
      logic signed [sktab_pkg::KEY_BITS-1:0] k;
      int                                    pos;
      int                                    limit;
      bit                                    hit;
      res = '0;
      k = r.key_id;
      limit = (capacity_copy > TABLE_DEPTH) ? TABLE_DEPTH : int'(capacity_copy);
      pos = 0;
      while (pos < fill_copy && key_copy[pos] < k)
         pos++;
      hit = (pos < fill_copy) && (key_copy[pos] == k);
      case (r.func)
         sktab_pkg::FUNC_INSERT: begin
            if (fill_copy >= limit)
               res.status = sktab_pkg::STATUS_FULL;
            else if (hit)
               res.status = sktab_pkg::STATUS_DUPLICATE;
            else begin
               for (int i = fill_copy; i > pos; i--) begin
                  key_copy[i] = key_copy[i-1];
                  pay_copy[i] = pay_copy[i-1];
               end
               key_copy[pos] = k;
               pay_copy[pos] = r.entry_payload;
               fill_copy++;
            end
         end
         sktab_pkg::FUNC_DELETE: begin
            if (fill_copy == 0)
               res.status = sktab_pkg::STATUS_EMPTY;
            else if (!hit)
               res.status = sktab_pkg::STATUS_NOT_FOUND;
            else begin
               for (int i = pos; i + 1 < fill_copy; i++) begin
                  key_copy[i] = key_copy[i+1];
                  pay_copy[i] = pay_copy[i+1];
               end
               fill_copy--;
            end
         end
         sktab_pkg::FUNC_LOOKUP: begin
            if (hit) begin
               res.found = 1'b1;
               res.payload_out = pay_copy[pos];
            end else
               res.status = sktab_pkg::STATUS_NOT_FOUND;
         end
         default: ;
      endcase
      res.entry_count = fill_copy[sktab_pkg::CAP_BITS-1:0];
      return res;
   endfunction

   function automatic void add_req(logic [1:0] f, logic signed [sktab_pkg::KEY_BITS-1:0] k,
                                   logic [sktab_pkg::PORT_PAY_W-1:0] p);
      stim_row_type row;
      row = '{default: '0};
      row.req = '{f, k, p};
      directed_rows.push_back(row);
   endfunction

   function automatic void add_typed(logic [1:0] f, logic signed [sktab_pkg::KEY_BITS-1:0] k,
                                     logic [sktab_pkg::PORT_PAY_W-1:0] p, logic [2:0] st,
                                     logic fnd, logic [sktab_pkg::PORT_PAY_W-1:0] po,
                                     logic [sktab_pkg::CAP_BITS-1:0] cnt);
      stim_row_type row;
      row = '{default: '0};
      row.req = '{f, k, p};
      row.typed = 1'b1;
      row.rsp = '{st, fnd, po, cnt};
      directed_rows.push_back(row);
   endfunction

   function automatic void add_cfg(logic [sktab_pkg::CAP_BITS-1:0] v);
      stim_row_type row;
      row = '{default: '0};
      row.is_cfg = 1'b1;
      row.cfg_value = v;
      directed_rows.push_back(row);
   endfunction

   task automatic compare_field(string name, logic [31:0] exp, logic [31:0] act);
      if (act !== exp) begin
         errors++;
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp, act);
      end
   endtask

   // Offer one request and hold it until the block takes it.
   task automatic send_request(sktab_pkg::req_type r, bit typed, sktab_pkg::rsp_type typed_rsp);
      req_valid      <= 1'b1;
      req_data       <= r;
      item_typed     <= typed;
      item_typed_rsp <= typed_rsp;
      do
         @(negedge clock);
      while (req_stall !== 1'b0);
      @(posedge clock);
   endtask

   task automatic maybe_pause();
      if (!quiet && $urandom_range(0, 99) < 20) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   // Stop offering and wait until every outstanding result is back.
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_results.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_capacity(logic [sktab_pkg::CAP_BITS-1:0] v);
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Receiver: random stall bursts, one long hold on request.
   initial begin
      rsp_stall = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (!quiet && $urandom_range(0, 99) < 25) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            rsp_stall <= 1'b0;
         end else
            rsp_stall <= 1'b0;
      end
   end

   // Monitor: sample between edges, where every signal is settled.
   always @(negedge clock) begin
      if (!reset) begin
         if (csr_write_enable)
            capacity_copy = csr_write_data;
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               errors++;
               $display("%0t: result with nothing expected: %p", $time, rsp_data);
            end else begin
               wanted = expected_results.pop_front();
               compare_field("status", 32'(wanted.status), 32'(rsp_data.status));
               compare_field("found", 32'(wanted.found), 32'(rsp_data.found));
               compare_field("payload_out", wanted.payload_out, rsp_data.payload_out);
               compare_field("entry_count", 32'(wanted.entry_count),
                             32'(rsp_data.entry_count));
               status_seen[rsp_data.status]++;
               if (int'(rsp_data.entry_count) > peak_fill)
                  peak_fill = int'(rsp_data.entry_count);
            end
         end
         if (req_valid && !req_stall) begin
            predicted = apply_request(req_data);
            if (item_typed)
               predicted = item_typed_rsp;
            expected_results.push_back(predicted);
            func_seen[req_data.func]++;
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            stuck_cycles = 0;
         else
            stuck_cycles++;
         if (stuck_cycles >= STUCK_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STUCK_LIMIT);
            $display("FAILURE");
            $finish;
         end
      end
   end

   initial begin
      logic [sktab_pkg::CAP_BITS-1:0] phase_cap [PHASE_COUNT];
      mix_type                        phase_mix [PHASE_COUNT];
      sktab_pkg::req_type             r;
      int                             roll;
      sktab_pkg::rsp_type             none;

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data         = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      item_typed       = 1'b0;
      item_typed_rsp   = '0;
      fill_copy        = 0;
      capacity_copy    = sktab_pkg::CAP_RESET;
      errors           = 0;
      stuck_cycles     = 0;
      peak_fill        = 0;
      hold_request     = 1'b0;
      quiet            = 1'b0;
      none             = '0;
      foreach (func_seen[i]) func_seen[i] = 0;
      foreach (status_seen[i]) status_seen[i] = 0;

      key_pool[0] = KEY_MIN;
      key_pool[1] = KEY_MAX;
      key_pool[2] = 0;
      key_pool[3] = -1;
      key_pool[4] = 1;
      key_pool[5] = KEY_MIN + 1;
      key_pool[6] = KEY_MAX - 1;
      for (int i = 7; i < POOL_SIZE; i++)
         key_pool[i] = $urandom;

      // empty table, then the extremes of the key range
      add_typed(sktab_pkg::FUNC_LOOKUP, 0, 0, sktab_pkg::STATUS_NOT_FOUND, 0, 0, 0);
      add_typed(sktab_pkg::FUNC_DELETE, 5, 0, sktab_pkg::STATUS_EMPTY, 0, 0, 0);
      add_typed(FUNC_UNUSED, 7, 32'hffff_ffff, sktab_pkg::STATUS_OK, 0, 0, 0);
      add_typed(sktab_pkg::FUNC_INSERT, KEY_MIN, 32'hffff_ffff, sktab_pkg::STATUS_OK, 0, 0, 1);
      add_typed(sktab_pkg::FUNC_INSERT, KEY_MAX, 0, sktab_pkg::STATUS_OK, 0, 0, 2);
      add_req(sktab_pkg::FUNC_INSERT, 0, 32'h1234_5678);
      add_req(sktab_pkg::FUNC_INSERT, -1, 32'ha5a5_a5a5);
      add_req(sktab_pkg::FUNC_INSERT, 1, 32'h5a5a_5a5a);
      add_typed(sktab_pkg::FUNC_INSERT, KEY_MAX, 1, sktab_pkg::STATUS_DUPLICATE, 0, 0, 5);
      add_typed(sktab_pkg::FUNC_LOOKUP, KEY_MIN, 0, sktab_pkg::STATUS_OK, 1, 32'hffff_ffff, 5);
      add_typed(sktab_pkg::FUNC_LOOKUP, KEY_MAX, 0, sktab_pkg::STATUS_OK, 1, 0, 5);
      add_req(sktab_pkg::FUNC_LOOKUP, -1, 0);
      add_typed(sktab_pkg::FUNC_LOOKUP, 2, 0, sktab_pkg::STATUS_NOT_FOUND, 0, 0, 5);
      add_typed(FUNC_UNUSED, KEY_MAX, 32'hffff_ffff, sktab_pkg::STATUS_OK, 0, 0, 5);
      add_typed(sktab_pkg::FUNC_DELETE, 2, 0, sktab_pkg::STATUS_NOT_FOUND, 0, 0, 5);
      add_req(sktab_pkg::FUNC_DELETE, 0, 0);
      add_req(sktab_pkg::FUNC_LOOKUP, 1, 0);
      add_req(sktab_pkg::FUNC_DELETE, KEY_MIN, 0);
      add_req(sktab_pkg::FUNC_LOOKUP, KEY_MAX, 0);
      // capacity at, then below, the fill level; then zero and saturated
      add_cfg(3);
      add_typed(sktab_pkg::FUNC_INSERT, 7, 1, sktab_pkg::STATUS_FULL, 0, 0, 3);
      add_cfg(2);
      add_typed(sktab_pkg::FUNC_INSERT, 8, 2, sktab_pkg::STATUS_FULL, 0, 0, 3);
      add_req(sktab_pkg::FUNC_DELETE, -1, 0);
      add_typed(sktab_pkg::FUNC_INSERT, 9, 3, sktab_pkg::STATUS_FULL, 0, 0, 2);
      add_cfg(0);
      add_typed(sktab_pkg::FUNC_INSERT, 9, 4, sktab_pkg::STATUS_FULL, 0, 0, 2);
      add_req(sktab_pkg::FUNC_LOOKUP, 1, 0);
      add_cfg(127);
      add_req(sktab_pkg::FUNC_INSERT, 9, 9);

      phase_cap[0] = 64;  phase_mix[0] = MIX_FILL;
      phase_cap[1] = 1;   phase_mix[1] = MIX_EVEN;
      phase_cap[2] = 127; phase_mix[2] = MIX_FILL;
      phase_cap[3] = sktab_pkg::CAP_BITS'($urandom_range(2, 63)); phase_mix[3] = MIX_DRAIN;
      phase_cap[4] = 0;   phase_mix[4] = MIX_EVEN;
      phase_cap[5] = 64;  phase_mix[5] = MIX_FILL;
      phase_cap[6] = 100; phase_mix[6] = MIX_DRAIN;
      phase_cap[7] = 64;  phase_mix[7] = MIX_EVEN;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_cfg) begin
            drain();
            write_capacity(directed_rows[i].cfg_value);
         end else begin
            send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);
            maybe_pause();
         end
      end

      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         drain();
         write_capacity(phase_cap[ph]);
         if (ph == 2)
            hold_request = 1'b1;
         if (ph == PHASE_COUNT - 1)
            quiet = 1'b1;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            roll = $urandom_range(0, 99);
            case (phase_mix[ph])
               MIX_FILL:  r.func = (roll < 60) ? sktab_pkg::FUNC_INSERT :
                                   (roll < 75) ? sktab_pkg::FUNC_DELETE :
                                   (roll < 98) ? sktab_pkg::FUNC_LOOKUP : FUNC_UNUSED;
               MIX_DRAIN: r.func = (roll < 20) ? sktab_pkg::FUNC_INSERT :
                                   (roll < 65) ? sktab_pkg::FUNC_DELETE :
                                   (roll < 98) ? sktab_pkg::FUNC_LOOKUP : FUNC_UNUSED;
               default:   r.func = (roll < 35) ? sktab_pkg::FUNC_INSERT :
                                   (roll < 65) ? sktab_pkg::FUNC_DELETE :
                                   (roll < 98) ? sktab_pkg::FUNC_LOOKUP : FUNC_UNUSED;
            endcase
            // mostly keys from the pool so that hits and duplicates are common
            if ($urandom_range(0, 9) == 0)
               r.key_id = $urandom;
            else
               r.key_id = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            roll = $urandom_range(0, 19);
            r.entry_payload = (roll == 0) ? '0 : (roll == 1) ? '1 : $urandom;
            send_request(r, 1'b0, none);
            maybe_pause();
         end
      end

      drain();
      repeat (10) @(posedge clock);

      $display("Covered %0d requests: %0d insert, %0d delete, %0d lookup, %0d unused func",
               func_seen[0] + func_seen[1] + func_seen[2] + func_seen[3],
               func_seen[sktab_pkg::FUNC_INSERT], func_seen[sktab_pkg::FUNC_DELETE],
               func_seen[sktab_pkg::FUNC_LOOKUP], func_seen[FUNC_UNUSED]);
      $display("Statuses: %0d ok, %0d full, %0d duplicate, %0d empty, %0d not found; peak %0d",
               status_seen[sktab_pkg::STATUS_OK], status_seen[sktab_pkg::STATUS_FULL],
               status_seen[sktab_pkg::STATUS_DUPLICATE], status_seen[sktab_pkg::STATUS_EMPTY],
               status_seen[sktab_pkg::STATUS_NOT_FOUND], peak_fill);
      if (errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
